@@ hw/rtl/spv_pkg.sv @@
package spv_pkg;

  localparam int unsigned EPOCH_DAY = 2451545;

  // scaled constants, floor(ratio * 2^48)
  localparam logic [127:0] Q_L0 = (128'd280460 << 48) / 128'd360000;
  localparam logic [127:0] Q_RL = (128'd36000771 << 48) / 128'd13149000000;
  localparam logic [127:0] Q_M0 = (128'd3575291092 << 48) / 128'd36000000000;
  localparam logic [127:0] Q_RM = (128'd3599905034 << 48) / 128'd1314900000000;
  localparam logic [127:0] Q_E0 = (128'd23439291 << 48) / 128'd360000000;
  localparam logic [127:0] Q_RE = (128'd130042 << 48) / 128'd131490000000000;
  localparam logic [127:0] Q_C1 = (128'd1914666471 << 48) / 128'd360000000000;
  localparam logic [127:0] Q_C2 = (128'd19994643 << 48) / 128'd360000000000;
  localparam logic [127:0] Q_R0 = (128'd140612 << 48) / 128'd1000000000;
  localparam logic [127:0] Q_R1 = (128'd16708617 << 48) / 128'd1000000000;
  localparam logic [127:0] Q_R2 = (128'd139589 << 48) / 128'd1000000000;

  localparam logic [127:0] Q_C1R = (Q_C1 + 128'd32768) >> 16;
  localparam logic [127:0] Q_C2R = (Q_C2 + 128'd32768) >> 16;
  localparam logic [127:0] Q_R0R = (Q_R0 + 128'd131072) >> 18;
  localparam logic [127:0] Q_R1R = (Q_R1 + 128'd131072) >> 18;
  localparam logic [127:0] Q_R2R = (Q_R2 + 128'd131072) >> 18;

  localparam logic signed [27:0] COEF_C1 = signed'(Q_C1R[27:0]);
  localparam logic signed [27:0] COEF_C2 = signed'(Q_C2R[27:0]);
  localparam logic signed [27:0] COEF_R1 = signed'(Q_R1R[27:0]);
  localparam logic signed [27:0] COEF_R2 = signed'(Q_R2R[27:0]);
  localparam logic signed [33:0] COEF_R0 = signed'(34'(Q_R0R[31:0]) + 34'd1073741824);

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam int PROD_W = 62;
  localparam int WIDE_W = 68;

  // angle index: mean longitude, mean anomaly, obliquity
  localparam int ANG_L = 0;
  localparam int ANG_M = 1;
  localparam int ANG_E = 2;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         q;
  } rot_t;

  function automatic logic [47:0] rate_of(input int k);
    logic [47:0] r;
    case (k)
      ANG_L:   r = Q_RL[47:0];
      ANG_M:   r = Q_RM[47:0];
      default: r = Q_RE[47:0];
    endcase
    return r;
  endfunction

  function automatic logic [47:0] offset_of(input int k);
    logic [47:0] r;
    case (k)
      ANG_L:   r = Q_L0[47:0];
      ANG_M:   r = Q_M0[47:0];
      default: r = Q_E0[47:0];
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] atan_turn(input int i);
    logic signed [32:0] r;
    case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;  2: r = 33'sd167458907;
      3: r = 33'sd85004756;    4: r = 33'sd42667331;   5: r = 33'sd21354465;
      6: r = 33'sd10679838;    7: r = 33'sd5340245;    8: r = 33'sd2670163;
      9: r = 33'sd1335087;     10: r = 33'sd667544;    11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;     14: r = 33'sd41722;
      15: r = 33'sd20861;      16: r = 33'sd10430;     17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;      20: r = 33'sd652;
      21: r = 33'sd326;        22: r = 33'sd163;       23: r = 33'sd81;
      24: r = 33'sd41;         25: r = 33'sd20;        26: r = 33'sd10;
      27: r = 33'sd5;          28: r = 33'sd3;         29: r = 33'sd1;
      30: r = 33'sd1;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

  function automatic rot_t rot_step(input rot_t v, input int s);
    rot_t r;
    logic signed [33:0] xs, ys;
    xs = v.x >>> s;
    ys = v.y >>> s;
    r.q = v.q;
    if (v.z >= 0) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - atan_turn(s);
    end else begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + atan_turn(s);
    end
    return r;
  endfunction

  function automatic rot_t rot_start(input logic [31:0] a);
    rot_t r;
    r.x = CORDIC_GAIN;
    r.y = '0;
    r.z = signed'({3'b000, a[29:0]});
    r.q = a[31:30];
    return r;
  endfunction

  // round to nearest, ties up, by 2^30
  function automatic logic signed [31:0] rnd30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + PROD_W'(64'd536870912)) >>> 30;
    return t[31:0];
  endfunction

  function automatic logic signed [33:0] rnd30w(input logic signed [WIDE_W-1:0] p);
    logic signed [WIDE_W-1:0] t;
    t = (p + WIDE_W'(64'd536870912)) >>> 30;
    return t[33:0];
  endfunction

endpackage

@@ hw/rtl/spv_in_if.sv @@
interface spv_in_if;
  logic        valid;
  logic        ready;
  logic [21:0] julian_day;
  logic [31:0] day_fraction;

  modport source (output valid, output julian_day, output day_fraction, input ready);
  modport sink (input valid, input julian_day, input day_fraction, output ready);
endinterface

@@ hw/rtl/spv_out_if.sv @@
interface spv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sun_x;
  logic signed [31:0] sun_y;
  logic signed [31:0] sun_z;

  modport source (output valid, output sun_x, output sun_y, output sun_z, input ready);
  modport sink (input valid, input sun_x, input sun_y, input sun_z, output ready);
endinterface

@@ hw/rtl/spv_cordic_cell.sv @@
module spv_cordic_cell #(
  parameter int STAGE = 0,
  parameter int SB_W  = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  spv_pkg::rot_t      a_i,
  input  spv_pkg::rot_t      b_i,
  input  logic [SB_W-1:0]    sb_i,
  output logic               vld_o,
  output spv_pkg::rot_t      a_o,
  output spv_pkg::rot_t      b_o,
  output logic [SB_W-1:0]    sb_o
);
  import spv_pkg::*;

  logic            vld_r;
  rot_t            a_r, b_r;
  logic [SB_W-1:0] sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= rot_step(a_i, STAGE);
      b_r  <= rot_step(b_i, STAGE);
      sb_r <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign a_o   = a_r;
  assign b_o   = b_r;
  assign sb_o  = sb_r;
endmodule

@@ hw/rtl/spv_cordic_chain.sv @@
module spv_cordic_chain #(
  parameter int STAGES = 24,
  parameter int SB_W   = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [31:0]        ang_a,
  input  logic [31:0]        ang_b,
  input  logic [SB_W-1:0]    sb_i,
  output logic               vld_o,
  output logic signed [33:0] sin_a,
  output logic signed [33:0] cos_a,
  output logic signed [33:0] sin_b,
  output logic signed [33:0] cos_b,
  output logic [SB_W-1:0]    sb_o
);
  import spv_pkg::*;

  rot_t            a_s  [STAGES+1];
  rot_t            b_s  [STAGES+1];
  logic            v_s  [STAGES+1];
  logic [SB_W-1:0] sb_s [STAGES+1];

  assign a_s[0]  = rot_start(ang_a);
  assign b_s[0]  = rot_start(ang_b);
  assign v_s[0]  = vld_i;
  assign sb_s[0] = sb_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    spv_cordic_cell #(.STAGE(i), .SB_W(SB_W)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (v_s[i]),
      .a_i   (a_s[i]),
      .b_i   (b_s[i]),
      .sb_i  (sb_s[i]),
      .vld_o (v_s[i+1]),
      .a_o   (a_s[i+1]),
      .b_o   (b_s[i+1]),
      .sb_o  (sb_s[i+1])
    );
  end

  // quadrant fold-back
  always_comb begin
    case (a_s[STAGES].q)
      2'd0:    begin cos_a = a_s[STAGES].x;  sin_a = a_s[STAGES].y;  end
      2'd1:    begin cos_a = -a_s[STAGES].y; sin_a = a_s[STAGES].x;  end
      2'd2:    begin cos_a = -a_s[STAGES].x; sin_a = -a_s[STAGES].y; end
      default: begin cos_a = a_s[STAGES].y;  sin_a = -a_s[STAGES].x; end
    endcase
    case (b_s[STAGES].q)
      2'd0:    begin cos_b = b_s[STAGES].x;  sin_b = b_s[STAGES].y;  end
      2'd1:    begin cos_b = -b_s[STAGES].y; sin_b = b_s[STAGES].x;  end
      2'd2:    begin cos_b = -b_s[STAGES].x; sin_b = -b_s[STAGES].y; end
      default: begin cos_b = b_s[STAGES].y;  sin_b = -b_s[STAGES].x; end
    endcase
  end

  assign vld_o = v_s[STAGES];
  assign sb_o  = sb_s[STAGES];
endmodule

@@ hw/rtl/sun_position_vector.sv @@
// sun position vector: low-precision solar ephemeris, fully pipelined
// in_ch carries a request: julian_day (22-bit day number) and day_fraction (Q0.32)
// out_ch returns sun_x, sun_y, sun_z, the inertial sun vector in AU with
// OUT_FRAC_BITS fraction bits, one result per request, in request order
// stages in order: two input stages, a chain of CORDIC cells for the anomaly
// harmonics, two stages for the longitude and distance, a second cell chain
// for longitude and obliquity, then four multiply and round stages into the
// output register; throughput is one request per cycle unless the receiver
// stalls; every cell of each chain steps two rotations at once and hands them
// to its neighbor on each clock that the pipeline advances
// the whole pipeline advances when the output register is empty or taken, so a
// stalled receiver freezes every stage and in_ch.ready drops with it
// synchronous reset clears all valid flags; the data registers are not reset
module sun_position_vector #(
  parameter int CORDIC_STAGES = 24,
  parameter int OUT_FRAC_BITS = 30
) (
  input logic      clk,
  input logic      rst_n,
  spv_in_if.sink   in_ch,
  spv_out_if.source out_ch
);
  import spv_pkg::*;

  localparam int SH = 60 - OUT_FRAC_BITS;

  logic adv;
  logic out_valid_r;
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: drift products, mod 2^48
  logic [47:0] dx;
  logic [47:0] lo_nxt [3];
  logic [23:0] hi_nxt [3];
  logic [47:0] f_nxt  [3];
  logic [47:0] lo_r   [3];
  logic [23:0] hi_r   [3];
  logic [47:0] f_r    [3];
  logic        s1_valid_r;

  always_comb begin
    logic [47:0] rt, plo, phi;
    logic [63:0] pf;
    dx = 48'({26'b0, in_ch.julian_day}) - 48'(EPOCH_DAY);
    for (int k = 0; k < 3; k++) begin
      rt  = rate_of(k);
      plo = dx * {24'b0, rt[23:0]};
      phi = dx * {24'b0, rt[47:24]};
      pf  = 64'(in_ch.day_fraction) * {32'b0, rt[47:16]};
      lo_nxt[k] = plo;
      hi_nxt[k] = phi[23:0];
      f_nxt[k]  = pf[63:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= lo_nxt[k];
        hi_r[k] <= hi_nxt[k];
        f_r[k]  <= f_nxt[k];
      end
    end
  end

  // stage 2: angles in turns
  logic [31:0] ang_nxt [3];
  logic [31:0] lm_r, ma_r, eps_r;
  logic        s2_valid_r;

  always_comb begin
    logic [47:0] sum, a48;
    for (int k = 0; k < 3; k++) begin
      sum = lo_r[k] + {hi_r[k], 24'b0} + f_r[k];
      a48 = (k == ANG_E) ? offset_of(k) - sum : offset_of(k) + sum;
      ang_nxt[k] = a48[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lm_r  <= ang_nxt[ANG_L];
      ma_r  <= ang_nxt[ANG_M];
      eps_r <= ang_nxt[ANG_E];
    end
  end

  // anomaly harmonics
  logic               c1_valid;
  logic signed [33:0] s1, k1, s2, k2;
  logic [63:0]        c1_sb;

  spv_cordic_chain #(.STAGES(CORDIC_STAGES), .SB_W(64)) u_chain_anom (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (s2_valid_r),
    .ang_a (ma_r),
    .ang_b ({ma_r[30:0], 1'b0}),
    .sb_i  ({lm_r, eps_r}),
    .vld_o (c1_valid),
    .sin_a (s1),
    .cos_a (k1),
    .sin_b (s2),
    .cos_b (k2),
    .sb_o  (c1_sb)
  );

  // stage 3: harmonic and distance products
  logic signed [PROD_W-1:0] ps1_r, ps2_r, pk1_r, pk2_r;
  logic [31:0]              lm3_r, eps3_r;
  logic                     s3_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ps1_r  <= PROD_W'(s1 * COEF_C1);
      ps2_r  <= PROD_W'(s2 * COEF_C2);
      pk1_r  <= PROD_W'(k1 * COEF_R1);
      pk2_r  <= PROD_W'(k2 * COEF_R2);
      lm3_r  <= c1_sb[63:32];
      eps3_r <= c1_sb[31:0];
    end
  end

  // stage 4: ecliptic longitude and distance
  logic [31:0]        le_r, eps4_r;
  logic signed [33:0] r_r;
  logic               s4_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      le_r   <= lm3_r + rnd30(ps1_r) + rnd30(ps2_r);
      r_r    <= COEF_R0 - 34'(rnd30(pk1_r)) - 34'(rnd30(pk2_r));
      eps4_r <= eps3_r;
    end
  end

  logic               c2_valid;
  logic signed [33:0] sl, cl, se, ce;
  logic [33:0]        c2_sb;

  spv_cordic_chain #(.STAGES(CORDIC_STAGES), .SB_W(34)) u_chain_lon (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (s4_valid_r),
    .ang_a (le_r),
    .ang_b (eps4_r),
    .sb_i  (r_r),
    .vld_o (c2_valid),
    .sin_a (sl),
    .cos_a (cl),
    .sin_b (se),
    .cos_b (ce),
    .sb_o  (c2_sb)
  );

  // stage 5..7: project onto the equator
  logic signed [WIDE_W-1:0] px_r, pt_r, py_r, pz_r;
  logic signed [33:0]       se5_r, ce5_r, se6_r, ce6_r, t6_r;
  logic signed [31:0]       x6_r, x7_r;
  logic                     s5_valid_r, s6_valid_r, s7_valid_r;
  logic signed [WIDE_W-1:0] half_lsb;
  logic signed [WIDE_W-1:0] x_full, y_full, z_full;

  assign half_lsb = WIDE_W'(1) <<< (SH - 1);
  assign x_full   = (px_r + half_lsb) >>> SH;
  assign y_full   = (py_r + half_lsb) >>> SH;
  assign z_full   = (pz_r + half_lsb) >>> SH;

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= WIDE_W'(signed'(c2_sb) * cl);
      pt_r  <= WIDE_W'(signed'(c2_sb) * sl);
      se5_r <= se;
      ce5_r <= ce;
      t6_r  <= rnd30w(pt_r);
      x6_r  <= x_full[31:0];
      se6_r <= se5_r;
      ce6_r <= ce5_r;
      py_r  <= WIDE_W'(t6_r * ce6_r);
      pz_r  <= WIDE_W'(t6_r * se6_r);
      x7_r  <= x6_r;
    end
  end

  // output register
  logic signed [31:0] out_x_r, out_y_r, out_z_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= x7_r;
      out_y_r <= y_full[31:0];
      out_z_r <= z_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      s7_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_ch.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= c1_valid;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= c2_valid;
      s6_valid_r  <= s5_valid_r;
      s7_valid_r  <= s6_valid_r;
      out_valid_r <= s7_valid_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.sun_x = out_x_r;
  assign out_ch.sun_y = out_y_r;
  assign out_ch.sun_z = out_z_r;

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_valid_r)
    else $error("accepted request did not enter the pipeline");
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(s2_valid_r) && $stable(s7_valid_r))
    else $error("pipeline moved while the receiver stalled");
  a_distance_pos: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> r_r > 0)
    else $error("sun distance not positive");
`endif
endmodule

@@ bench/sun_position_vector_tb.sv @@
module sun_position_vector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [21:0] julian_day;
    logic [31:0] day_fraction;
    bit          drain;
  } stamp_t;

  typedef struct {
    logic [31:0] sun_x;
    logic [31:0] sun_y;
    logic [31:0] sun_z;
  } sun_vec_t;

  localparam int STAGES       = 24;
  localparam int FRAC_BITS    = 30;
  localparam int LATENCY      = 2 * STAGES + 8;
  localparam int IDLE_LIMIT   = 3000;
  localparam int N_RANDOM     = 1130;
  localparam int STALL_AFTER  = 400;
  localparam int STALL_CYCLES = 300;
  localparam int DAY_LO       = 2415021;
  localparam int DAY_HI       = 2488070;

  logic clk;
  logic rst_n;

  spv_in_if  in_ch ();
  spv_out_if out_ch ();

  sun_position_vector #(.CORDIC_STAGES(STAGES), .OUT_FRAC_BITS(FRAC_BITS)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  stamp_t   stamp_q[$];
  sun_vec_t sun_vec_q[$];
  int       errors;
  int       send_gap;
  int       recv_gap;
  int       recv_stall;
  int       results_seen;
  int       idle_cycles;

  longint atan_tab[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // floor(num / den) in Q0.48
  function automatic logic [63:0] turns48(logic [127:0] num, logic [127:0] den);
    logic [127:0] t;
    t = (num << 48) / den;
    return t[63:0];
  endfunction

  function automatic longint round_shift(longint p, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    return (p + half) >>> s;
  endfunction

  function automatic logic [63:0] angle_drift(logic [63:0] rate, logic [63:0] days,
                                              logic [63:0] frac);
    return days * rate + ((frac * (rate >> 16)) >> 16);
  endfunction

  function automatic void sincos(input logic [31:0] a, output longint sn,
                                 output longint cs);
    longint x, y, z, nx;
    x = 652032874;
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_tab[i];
      end
      x = nx;
    end
    case (a[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic sun_vec_t sun_vector(stamp_t s);
    sun_vec_t v;
    logic [63:0] days, frac, l0, rl, m0, rm, e0, re, t64;
    logic [31:0] lm, ma, eps, le;
    longint c1, c2, r0, r1, r2;
    longint s1, k1, s2, k2, sl, cl, se, ce, sun_dist, t;
    days = 64'(longint'(s.julian_day) - 2451545);
    frac = 64'(s.day_fraction);
    l0 = turns48(280460, 360000);
    rl = turns48(36000771, 128'd13149000000);
    m0 = turns48(128'd3575291092, 128'd36000000000);
    rm = turns48(128'd3599905034, 128'd1314900000000);
    e0 = turns48(23439291, 360000000);
    re = turns48(130042, 128'd131490000000000);
    c1 = longint'((turns48(1914666471, 128'd360000000000) + 64'd32768) >> 16);
    c2 = longint'((turns48(19994643, 128'd360000000000) + 64'd32768) >> 16);
    r0 = (longint'(1) <<< 30) + longint'((turns48(140612, 1000000000) + 64'd131072) >> 18);
    r1 = longint'((turns48(16708617, 1000000000) + 64'd131072) >> 18);
    r2 = longint'((turns48(139589, 1000000000) + 64'd131072) >> 18);

    t64 = (l0 + angle_drift(rl, days, frac)) >> 16;
    lm = t64[31:0];
    t64 = (m0 + angle_drift(rm, days, frac)) >> 16;
    ma = t64[31:0];
    t64 = (e0 - angle_drift(re, days, frac)) >> 16;
    eps = t64[31:0];

    sincos(ma, s1, k1);
    sincos({ma[30:0], 1'b0}, s2, k2);
    t64 = 64'(lm) + 64'(round_shift(s1 * c1, 30)) + 64'(round_shift(s2 * c2, 30));
    le = t64[31:0];
    sun_dist = r0 - round_shift(r1 * k1, 30) - round_shift(r2 * k2, 30);

    sincos(le, sl, cl);
    sincos(eps, se, ce);
    t = round_shift(sun_dist * sl, 30);
    v.sun_x = 32'(round_shift(sun_dist * cl, 60 - FRAC_BITS));
    v.sun_y = 32'(round_shift(t * ce, 60 - FRAC_BITS));
    v.sun_z = 32'(round_shift(t * se, 60 - FRAC_BITS));
    return v;
  endfunction

  function automatic void add_stamp(logic [21:0] jd, logic [31:0] fr, bit drain);
    stamp_t s;
    s.julian_day = jd;
    s.day_fraction = fr;
    s.drain = drain;
    stamp_q.push_back(s);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        stamp_t s;
        s.julian_day = in_ch.julian_day;
        s.day_fraction = in_ch.day_fraction;
        sun_vec_q.push_back(sun_vector(s));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (stamp_q.size() > 0 && !(stamp_q[0].drain && sun_vec_q.size() > 0)) begin
          stamp_t s;
          s = stamp_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.julian_day <= s.julian_day;
          in_ch.day_fraction <= s.day_fraction;
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
      recv_stall = 0;
      results_seen = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (sun_vec_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                   out_ch.sun_x, out_ch.sun_y, out_ch.sun_z);
        end else begin
          sun_vec_t e;
          e = sun_vec_q.pop_front();
          if (out_ch.sun_x !== e.sun_x) begin
            errors++;
            $display("%0t: sun_x expected %h actual %h", $time, e.sun_x, out_ch.sun_x);
          end
          if (out_ch.sun_y !== e.sun_y) begin
            errors++;
            $display("%0t: sun_y expected %h actual %h", $time, e.sun_y, out_ch.sun_y);
          end
          if (out_ch.sun_z !== e.sun_z) begin
            errors++;
            $display("%0t: sun_z expected %h actual %h", $time, e.sun_z, out_ch.sun_z);
          end
        end
        // one long hold-off so the pipeline fills and stalls the input
        if (results_seen == STALL_AFTER) recv_stall = STALL_CYCLES;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [21:0] jd;
    errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.julian_day = '0;
    in_ch.day_fraction = '0;
    out_ch.ready = 1'b0;

    // directed: epoch, range ends, field extremes, out-of-range days
    add_stamp(22'd2451545, 32'h0000_0000, 0);
    add_stamp(22'd2451545, 32'h8000_0000, 0);
    add_stamp(22'd2451545, 32'hFFFF_FFFF, 0);
    add_stamp(22'(DAY_LO), 32'h0000_0000, 0);
    add_stamp(22'(DAY_LO), 32'hFFFF_FFFF, 0);
    add_stamp(22'(DAY_HI), 32'h0000_0000, 0);
    add_stamp(22'(DAY_HI), 32'hFFFF_FFFF, 0);
    add_stamp(22'd2451544, 32'hFFFF_FFFF, 0);
    add_stamp(22'd0, 32'h0000_0000, 0);
    add_stamp(22'd0, 32'hFFFF_FFFF, 0);
    add_stamp(22'h3F_FFFF, 32'h0000_0000, 0);
    add_stamp(22'h3F_FFFF, 32'hFFFF_FFFF, 0);
    add_stamp(22'h2A_AAAA, 32'h5555_5555, 0);
    add_stamp(22'h15_5555, 32'hAAAA_AAAA, 0);
    add_stamp(22'd2460000, 32'h4000_0000, 0);
    add_stamp(22'd2440000, 32'hC000_0000, 0);
    add_stamp(22'd2470000, 32'h0000_0001, 0);
    add_stamp(22'd2451545, 32'h7FFF_FFFF, 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(99) < 85) jd = 22'($urandom_range(DAY_HI, DAY_LO));
      else jd = 22'($urandom);
      // halfway through the sender waits for every result before going on
      add_stamp(jd, $urandom, n == N_RANDOM / 2);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (stamp_q.size() > 0 || in_ch.valid);
    do @(posedge clk); while (sun_vec_q.size() > 0);
    repeat (LATENCY + 10) @(posedge clk);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/spv_pkg.sv
hw/rtl/spv_in_if.sv
hw/rtl/spv_out_if.sv
hw/rtl/spv_cordic_cell.sv
hw/rtl/spv_cordic_chain.sv
hw/rtl/sun_position_vector.sv
bench/sun_position_vector_tb.sv
